// ===== sv/cstrip_pkg.sv =====
// cstrip_pkg: shared types and character codes for the C comment stripper.
// No dependencies; imported by every module of the block.
`default_nettype none

package cstrip_pkg;

    localparam int ByteW  = 8;
    localparam int ModeW  = 3;
    localparam int CountW = 2;

    localparam logic [ByteW-1:0] CH_SLASH     = 8'h2F;
    localparam logic [ByteW-1:0] CH_STAR      = 8'h2A;
    localparam logic [ByteW-1:0] CH_BACKSLASH = 8'h5C;
    localparam logic [ByteW-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [ByteW-1:0] CH_QUOTE     = 8'h22;

    typedef struct packed {
        logic [ByteW-1:0] in_byte;
        logic             end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [ByteW-1:0] out_byte;
        logic             run_last;
    } t_out_item;

    typedef struct packed {
        logic [CountW-1:0] cnt;
        t_out_item         res0;
        t_out_item         res1;
    } t_step_res;

endpackage

`default_nettype wire

// ===== sv/cstrip_step.sv =====
// cstrip_step: scan mode transition and result generation for one byte.
// Depends on cstrip_pkg.
`default_nettype none

module cstrip_step
    import cstrip_pkg::*;
(
    input  wire logic [ModeW-1:0] i_mode,
    input  wire t_in_item         i_item,
    output logic [ModeW-1:0]      o_next_mode,
    output t_step_res             o_res
);

    localparam logic [ModeW-1:0] MODE_NORMAL     = 3'd0;
    localparam logic [ModeW-1:0] MODE_SLASH      = 3'd1;
    localparam logic [ModeW-1:0] MODE_BLOCK      = 3'd2;
    localparam logic [ModeW-1:0] MODE_BLOCK_STAR = 3'd3;
    localparam logic [ModeW-1:0] MODE_LINE       = 3'd4;
    localparam logic [ModeW-1:0] MODE_LINE_SKIP  = 3'd5;
    localparam logic [ModeW-1:0] MODE_STRING     = 3'd6;
    localparam logic [ModeW-1:0] MODE_STRING_ESC = 3'd7;

    logic [ByteW-1:0]  b;
    logic [ModeW-1:0]  nm;
    logic [CountW-1:0] cnt;
    logic [ByteW-1:0]  e0;
    logic [ByteW-1:0]  e1;

    assign b = i_item.in_byte;

    always_comb begin
        nm  = i_mode;
        cnt = 2'd0;
        e0  = '0;
        e1  = '0;
        case (i_mode)
            MODE_NORMAL: begin
                if (b == CH_SLASH) begin
                    nm = MODE_SLASH;
                end else begin
                    cnt = 2'd1;
                    e0  = b;
                    nm  = (b == CH_QUOTE) ? MODE_STRING : MODE_NORMAL;
                end
            end
            MODE_SLASH: begin
                if (b == CH_STAR) begin
                    nm = MODE_BLOCK;
                end else if (b == CH_SLASH) begin
                    nm = MODE_LINE;
                end else begin
                    cnt = 2'd2;
                    e0  = CH_SLASH;
                    e1  = b;
                    nm  = (b == CH_QUOTE) ? MODE_STRING : MODE_NORMAL;
                end
            end
            MODE_BLOCK: begin
                nm = (b == CH_STAR) ? MODE_BLOCK_STAR : MODE_BLOCK;
            end
            MODE_BLOCK_STAR: begin
                if (b == CH_SLASH) begin
                    nm = MODE_NORMAL;
                end else if (b == CH_STAR) begin
                    nm = MODE_BLOCK_STAR;
                end else begin
                    nm = MODE_BLOCK;
                end
            end
            MODE_LINE: begin
                if (b == CH_NEWLINE) begin
                    cnt = 2'd1;
                    e0  = b;
                    nm  = MODE_NORMAL;
                end else if (b == CH_BACKSLASH) begin
                    nm = MODE_LINE_SKIP;
                end else begin
                    nm = MODE_LINE;
                end
            end
            MODE_LINE_SKIP: begin
                nm = (b == CH_NEWLINE) ? MODE_LINE : MODE_LINE_SKIP;
            end
            MODE_STRING: begin
                cnt = 2'd1;
                e0  = b;
                if (b == CH_BACKSLASH) begin
                    nm = MODE_STRING_ESC;
                end else if (b == CH_QUOTE) begin
                    nm = MODE_NORMAL;
                end else begin
                    nm = MODE_STRING;
                end
            end
            default: begin
                cnt = 2'd1;
                e0  = b;
                nm  = MODE_STRING;
            end
        endcase

        // flush a held slash and return to normal mode at end of text
        if (i_item.end_of_text) begin
            if (nm == MODE_SLASH) begin
                cnt = 2'd1;
                e0  = CH_SLASH;
            end
            nm = MODE_NORMAL;
        end
    end

    assign o_next_mode            = nm;
    assign o_res.cnt              = cnt;
    assign o_res.res0.out_byte    = e0;
    assign o_res.res0.run_last    = (cnt == 2'd1);
    assign o_res.res1.out_byte    = e1;
    assign o_res.res1.run_last    = 1'b1;

endmodule

`default_nettype wire

// ===== sv/cstrip_obuf.sv =====
// cstrip_obuf: two-slot result register feeding the output channel.
// Depends on cstrip_pkg; loaded from cstrip_step results.
`default_nettype none

module cstrip_obuf
    import cstrip_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_load,
    input  wire t_step_res i_res,
    output logic           o_load_ok,
    output logic           o_valid,
    input  wire logic      i_stall,
    output t_out_item      o_item
);

    logic [CountW-1:0] r_cnt;
    t_out_item         r_slot0;
    t_out_item         r_slot1;
    logic              pop;
    logic [CountW-1:0] remain;

    assign o_valid   = (r_cnt != 2'd0);
    assign o_item    = r_slot0;
    assign pop       = o_valid && !i_stall;
    assign remain    = r_cnt - {1'b0, pop};
    assign o_load_ok = (remain == 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_res.cnt;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_slot0 <= i_res.res0;
            r_slot1 <= i_res.res1;
        end else if (pop) begin
            r_slot0 <= r_slot1;
        end
    end

    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result count overflow");

    a_pair_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 |-> !r_slot0.run_last && r_slot1.run_last)
        else $error("bad run_last on result pair");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd1 |-> r_slot0.run_last)
        else $error("single result not marked last");

    a_load_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> r_cnt == 2'd0 || (r_cnt == 2'd1 && pop))
        else $error("load over pending results");

endmodule

`default_nettype wire

// ===== sv/c_comment_stripper.sv =====
// c_comment_stripper: top level; input register, mode register, result buffer.
// Accepted items go to the input register; their results load the result buffer.
// Throughput: 1 item per cycle while the output is not stalled and each item yields
// at most one result; an item yielding two results holds the input side while its first result is sent.
// Reset: synchronous active low; mode returns to normal text, all buffers empty.
`default_nettype none

module c_comment_stripper
    import cstrip_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_stall,
    input  wire t_in_item i_item,
    output logic          o_valid,
    input  wire logic     i_stall,
    output t_out_item     o_item
);

    logic             r_in_valid;
    t_in_item         r_in_item;
    logic [ModeW-1:0] r_mode;
    logic [ModeW-1:0] n_mode;
    t_step_res        step_res;
    logic             load_ok;
    logic             proc;
    logic             accept;

    assign proc    = r_in_valid && load_ok;
    assign o_stall = r_in_valid && !proc;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= accept || (r_in_valid && !proc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_item <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= '0;
        end else if (proc) begin
            r_mode <= n_mode;
        end
    end

    cstrip_step u_step (
        .i_mode      (r_mode),
        .i_item      (r_in_item),
        .o_next_mode (n_mode),
        .o_res       (step_res)
    );

    cstrip_obuf u_obuf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (proc),
        .i_res     (step_res),
        .o_load_ok (load_ok),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_item    (o_item)
    );

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// tb_top: self-checking testbench for c_comment_stripper. Drives C-like text one
// item per byte, predicts the kept bytes in order and checks every result item.
// Depends on cstrip_pkg and the c_comment_stripper RTL.

module tb_top;
    import cstrip_pkg::*;

    typedef enum logic [2:0] {
        SCAN_TEXT, SCAN_SLASH, SCAN_BLOCK, SCAN_BLOCK_STAR,
        SCAN_LINE, SCAN_LINE_SKIP, SCAN_STR, SCAN_STR_ESC
    } t_scan;

    typedef struct packed {
        t_in_item   item;
        logic       typed;
        logic [1:0] n_kept;
        logic [7:0] kept0;
        logic [7:0] kept1;
    } t_row;

    localparam int NUM_ROWS    = 25;
    localparam int PHASE_ITEMS = 200;
    localparam int HOLD_CYCLES = 80;
    localparam int TAIL_CYCLES = 20;
    localparam int STALL_LIMIT = 1000;

    localparam t_row DIR_ROWS [0:NUM_ROWS-1] = '{
        '{'{8'h00, 1'b0}, 1'b1, 2'd1, 8'h00, 8'h00},
        '{'{8'hFF, 1'b0}, 1'b1, 2'd1, 8'hFF, 8'h00},
        '{'{CH_SLASH, 1'b0}, 1'b1, 2'd0, 8'h00, 8'h00},
        '{'{8'h61, 1'b0}, 1'b1, 2'd2, CH_SLASH, 8'h61},
        '{'{CH_SLASH, 1'b0}, 1'b0, 2'd0, 8'h00, 8'h00},
        '{'{CH_STAR, 1'b0}, 1'b0, 2'd0, 8'h00, 8'h00},
        '{'{CH_SLASH, 1'b0}, 1'b0, 2'd0, 8'h00, 8'h00},
        '{'{8'h78, 1'b0}, 1'b0, 2'd0, 8'h00, 8'h00},
        '{'{CH_STAR, 1'b0}, 1'b0, 2'd0, 8'h00, 8'h00},
        '{'{CH_SLASH, 1'b0}, 1'b1, 2'd0, 8'h00, 8'h00},
        '{'{CH_SLASH, 1'b0}, 1'b0, 2'd0, 8'h00, 8'h00},
        '{'{CH_SLASH, 1'b0}, 1'b0, 2'd0, 8'h00, 8'h00},
        '{'{CH_BACKSLASH, 1'b0}, 1'b0, 2'd0, 8'h00, 8'h00},
        '{'{CH_NEWLINE, 1'b0}, 1'b0, 2'd0, 8'h00, 8'h00},
        '{'{8'h64, 1'b0}, 1'b0, 2'd0, 8'h00, 8'h00},
        '{'{CH_NEWLINE, 1'b0}, 1'b1, 2'd1, CH_NEWLINE, 8'h00},
        '{'{CH_QUOTE, 1'b0}, 1'b0, 2'd0, 8'h00, 8'h00},
        '{'{CH_SLASH, 1'b0}, 1'b0, 2'd0, 8'h00, 8'h00},
        '{'{CH_BACKSLASH, 1'b0}, 1'b0, 2'd0, 8'h00, 8'h00},
        '{'{CH_QUOTE, 1'b0}, 1'b0, 2'd0, 8'h00, 8'h00},
        '{'{CH_NEWLINE, 1'b0}, 1'b0, 2'd0, 8'h00, 8'h00},
        '{'{CH_QUOTE, 1'b0}, 1'b0, 2'd0, 8'h00, 8'h00},
        '{'{CH_SLASH, 1'b1}, 1'b1, 2'd1, CH_SLASH, 8'h00},
        '{'{CH_SLASH, 1'b0}, 1'b0, 2'd0, 8'h00, 8'h00},
        '{'{CH_STAR, 1'b1}, 1'b1, 2'd0, 8'h00, 8'h00}
    };

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_stall;
    t_in_item  i_item  = '0;
    logic      o_valid;
    logic      i_stall = 1'b0;
    t_out_item o_item;

    t_scan     scan_state = SCAN_TEXT;
    t_out_item kept_q[$];
    bit        mode_seen[8];
    int        send_idle_pct  = 10;
    int        recv_stall_pct = 51;
    int        hold_req       = 0;
    int        hold_left      = 0;
    int        err_cnt        = 0;
    int        items_sent     = 0;
    int        eot_sent       = 0;
    int        kept_checked   = 0;
    int        idle_run       = 0;

    c_comment_stripper dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic void add_kept(inout t_step_res r, input logic [7:0] b);
        if (r.cnt == 2'd0) begin
            r.res0 = '{b, 1'b0};
        end else begin
            r.res1 = '{b, 1'b0};
        end
        r.cnt = r.cnt + 2'd1;
    endfunction

    function automatic t_scan text_byte(inout t_step_res r, input logic [7:0] b);
        if (b == CH_SLASH) return SCAN_SLASH;
        add_kept(r, b);
        return (b == CH_QUOTE) ? SCAN_STR : SCAN_TEXT;
    endfunction

    function automatic t_step_res strip_byte(input t_in_item it);
        t_step_res  r;
        t_scan      nxt;
        logic [7:0] b;
        r = '0;
        b = it.in_byte;
        nxt = scan_state;
        case (scan_state)
            SCAN_TEXT: nxt = text_byte(r, b);
            SCAN_SLASH: begin
                if (b == CH_STAR) begin
                    nxt = SCAN_BLOCK;
                end else if (b == CH_SLASH) begin
                    nxt = SCAN_LINE;
                end else begin
                    add_kept(r, CH_SLASH);
                    nxt = text_byte(r, b);
                end
            end
            SCAN_BLOCK: nxt = (b == CH_STAR) ? SCAN_BLOCK_STAR : SCAN_BLOCK;
            SCAN_BLOCK_STAR: begin
                if (b == CH_SLASH) nxt = SCAN_TEXT;
                else if (b == CH_STAR) nxt = SCAN_BLOCK_STAR;
                else nxt = SCAN_BLOCK;
            end
            SCAN_LINE: begin
                if (b == CH_NEWLINE) begin
                    add_kept(r, b);
                    nxt = SCAN_TEXT;
                end else if (b == CH_BACKSLASH) begin
                    nxt = SCAN_LINE_SKIP;
                end else begin
                    nxt = SCAN_LINE;
                end
            end
            SCAN_LINE_SKIP: nxt = (b == CH_NEWLINE) ? SCAN_LINE : SCAN_LINE_SKIP;
            SCAN_STR: begin
                add_kept(r, b);
                if (b == CH_BACKSLASH) nxt = SCAN_STR_ESC;
                else if (b == CH_QUOTE) nxt = SCAN_TEXT;
                else nxt = SCAN_STR;
            end
            default: begin
                add_kept(r, b);
                nxt = SCAN_STR;
            end
        endcase
        if (it.end_of_text) begin
            if (nxt == SCAN_SLASH) add_kept(r, CH_SLASH);
            nxt = SCAN_TEXT;
        end
        if (r.cnt == 2'd1) r.res0.run_last = 1'b1;
        if (r.cnt == 2'd2) r.res1.run_last = 1'b1;
        scan_state = nxt;
        return r;
    endfunction

    task automatic send_item(input t_in_item it, input bit typed, input t_step_res typed_res);
        t_step_res r;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        do @(posedge i_clk); while (!(i_valid && !o_stall));
        mode_seen[scan_state] = 1'b1;
        r = strip_byte(it);
        if (typed) r = typed_res;
        if (r.cnt != 2'd0) kept_q.push_back(r.res0);
        if (r.cnt == 2'd2) kept_q.push_back(r.res1);
        items_sent++;
        if (it.end_of_text) eot_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        t_in_item it;
        it.in_byte     = b;
        it.end_of_text = ($urandom_range(49) == 0);
        send_item(it, 1'b0, '0);
    endtask

    function automatic logic [7:0] pick_byte(input logic [7:0] a, input logic [7:0] c);
        int r;
        r = $urandom_range(9);
        if (r < 2) return a;
        if (r < 4) return c;
        return 8'($urandom_range(255));
    endfunction

    task automatic gen_token();
        int kind;
        int len;
        kind = $urandom_range(99);
        len  = $urandom_range(8);
        if (kind < 30) begin
            repeat (len + 1) send_byte(8'($urandom_range(255)));
        end else if (kind < 45) begin
            send_byte(CH_SLASH);
            send_byte(CH_STAR);
            repeat (len) send_byte(pick_byte(CH_STAR, CH_SLASH));
            send_byte(CH_STAR);
            send_byte(CH_SLASH);
        end else if (kind < 60) begin
            send_byte(CH_SLASH);
            send_byte(CH_SLASH);
            repeat (len) begin
                if ($urandom_range(4) == 0) begin
                    send_byte(CH_BACKSLASH);
                    send_byte(8'($urandom_range(255)));
                    send_byte(CH_NEWLINE);
                end else begin
                    send_byte(pick_byte(CH_SLASH, CH_STAR));
                end
            end
            send_byte(CH_NEWLINE);
        end else if (kind < 75) begin
            send_byte(CH_QUOTE);
            repeat (len) begin
                if ($urandom_range(4) == 0) begin
                    send_byte(CH_BACKSLASH);
                    send_byte(pick_byte(CH_QUOTE, CH_BACKSLASH));
                end else begin
                    send_byte(pick_byte(CH_NEWLINE, CH_SLASH));
                end
            end
            send_byte(CH_QUOTE);
        end else if (kind < 88) begin
            send_byte(CH_SLASH);
            send_byte(8'($urandom_range(255)));
        end else begin
            send_byte(8'($urandom_range(255)));
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (kept_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic report(input string what, input logic [7:0] want, input logic [7:0] got);
        err_cnt++;
        $display("%0t: %s mismatch: expected %02h, actual %02h", $time, what, want, got);
    endtask

    always @(negedge i_clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            kept_checked++;
            if (kept_q.size() == 0) begin
                report("unexpected item, out_byte", 8'h00, o_item.out_byte);
            end else begin
                want = kept_q.pop_front();
                if (o_item.out_byte !== want.out_byte) begin
                    report("out_byte", want.out_byte, o_item.out_byte);
                end
                if (o_item.run_last !== want.run_last) begin
                    report("run_last", 8'(want.run_last), 8'(o_item.run_last));
                end
            end
        end
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_run = 0;
        end else begin
            idle_run++;
            if (idle_run >= STALL_LIMIT) begin
                $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
                $display("** c_comment_stripper: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        t_step_res typed_res;
        bit        held;
        int        n_modes;
        held = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < NUM_ROWS; k++) begin
            typed_res      = '0;
            typed_res.cnt  = DIR_ROWS[k].n_kept;
            typed_res.res0 = '{DIR_ROWS[k].kept0, DIR_ROWS[k].n_kept == 2'd1};
            typed_res.res1 = '{DIR_ROWS[k].kept1, 1'b1};
            send_item(DIR_ROWS[k].item, DIR_ROWS[k].typed, typed_res);
        end

        for (int phase = 0; phase < 3; phase++) begin
            wait_drained();
            case (phase)
                0: begin
                    send_idle_pct  = 10;
                    recv_stall_pct = 51;
                end
                1: begin
                    send_idle_pct  = 51;
                    recv_stall_pct = 10;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            while (items_sent < NUM_ROWS + (phase + 1) * PHASE_ITEMS) begin
                if (!held && items_sent >= NUM_ROWS + 60) begin
                    hold_req = HOLD_CYCLES;
                    held     = 1'b1;
                end
                gen_token();
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        n_modes = 0;
        foreach (mode_seen[m]) n_modes += mode_seen[m];
        $display("Run covered %0d items (%0d directed, %0d ending the text), %0d results checked",
                 items_sent, NUM_ROWS, eot_sent, kept_checked);
        $display("Scan modes entered: %0d of 8; three idle mixes and a %0d-cycle output hold-off",
                 n_modes, HOLD_CYCLES);
        if (err_cnt == 0) begin
            $display("** c_comment_stripper: PASSED **");
        end else begin
            $display("** c_comment_stripper: FAILED **");
        end
        $finish;
    end

endmodule
